@@ hw/rtl/mfr_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_pkg
// Types, constants and helper functions for the media fragment reassembler.
// ---------------------------------------------------------------------------
package mfr_pkg;

  localparam int unsigned FrameBytesDefault = 65536;
  localparam int unsigned HeaderBytes = 16;
  localparam logic [4:0] PosMax = 5'd31;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REQ_PKT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Operation handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_READ    = 2'd1,
    OP_DESC    = 2'd2
  } op_e;

  function automatic logic is_key_nal(input logic [7:0] b);
    logic [5:0] hevc;
    hevc = b[6:1];
    return (hevc == 6'd19) || (hevc == 6'd20) || (hevc == 6'd32) || (b[4:0] == 5'd5);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mfr_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_back
// Frame store with a registered read port and output register.
// ---------------------------------------------------------------------------
module mfr_back import mfr_pkg::*; #(
  parameter int unsigned FrameBytes = FrameBytesDefault,
  localparam int unsigned AddrW = $clog2(FrameBytes)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         op_valid_i,
  output logic              op_ready_o,
  input  wire op_e          op_kind_i,
  input  wire logic         op_chan_i,
  input  wire logic [AddrW-1:0] op_addr_i,
  input  wire logic         op_hit_i,
  input  wire logic [7:0]   op_byte_i,
  input  wire logic         op_key_i,
  input  wire logic [31:0]  op_ts_i,
  input  wire logic [31:0]  op_codec_i,
  input  wire logic [31:0]  op_len_i,
  input  wire logic         op_trunc_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic              result_kind_o,
  output logic              is_video_o,
  output logic              is_keyframe_o,
  output logic [31:0]       timestamp_ms_o,
  output logic [31:0]       codec_fourcc_o,
  output logic [31:0]       frame_length_o,
  output logic              truncated_o,
  output logic [7:0]        read_byte_o,
  output logic              read_valid_o
);

  localparam int unsigned Depth = 2 ** (AddrW + 1);

  logic [7:0]  mem_q [Depth];
  logic [7:0]  rd_q;
  logic        out_valid_q;
  logic        kind_q, video_q, key_q, trunc_q, rvalid_q;
  logic [31:0] ts_q, codec_q, len_q;
  logic        take, wr_en;

  // The output stage is one register; a new op enters when it is empty or
  // drains in this cycle. Payload writes produce nothing and always proceed.
  // A descriptor may also carry the final byte of its frame.
  assign op_ready_o = (op_kind_i == OP_PAYLOAD) || !out_valid_q || out_ready_i;
  assign take  = op_valid_i && op_ready_o;
  assign wr_en = take && ((op_kind_i == OP_PAYLOAD) || ((op_kind_i == OP_DESC) && op_hit_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[{op_chan_i, op_addr_i}] <= op_byte_i;
    end
    if (take && op_kind_i == OP_READ) begin
      rd_q <= op_hit_i ? mem_q[{op_chan_i, op_addr_i}] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && op_kind_i != OP_PAYLOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && op_kind_i != OP_PAYLOAD) begin
      kind_q   <= (op_kind_i == OP_READ);
      video_q  <= (op_kind_i == OP_DESC) && !op_chan_i;
      key_q    <= (op_kind_i == OP_DESC) && op_key_i;
      ts_q     <= (op_kind_i == OP_DESC) ? op_ts_i : 32'd0;
      codec_q  <= (op_kind_i == OP_DESC) ? op_codec_i : 32'd0;
      len_q    <= (op_kind_i == OP_DESC) ? op_len_i : 32'd0;
      trunc_q  <= (op_kind_i == OP_DESC) && op_trunc_i;
      rvalid_q <= (op_kind_i == OP_READ) && op_hit_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign is_video_o     = video_q;
  assign is_keyframe_o  = key_q;
  assign timestamp_ms_o = ts_q;
  assign codec_fourcc_o = codec_q;
  assign frame_length_o = len_q;
  assign truncated_o    = trunc_q;
  assign read_valid_o   = rvalid_q;
  assign read_byte_o    = kind_q ? rd_q : 8'd0;

endmodule
`default_nettype wire

@@ hw/rtl/mfr_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_queue
// Short FIFO of operations between the front and back parts.
// ---------------------------------------------------------------------------
module mfr_queue import mfr_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      out_data_o
);

  logic [Width-1:0] slot_q [QueueDepth];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'(QueueDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mfr_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mfr_front
// Header parser and per-channel frame bookkeeping.
// ---------------------------------------------------------------------------
module mfr_front import mfr_pkg::*; #(
  parameter int unsigned FrameBytes = FrameBytesDefault,
  localparam int unsigned AddrW = $clog2(FrameBytes)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [1:0]   req_type_i,
  input  wire logic [7:0]   channel_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         packet_last_i,
  input  wire logic [15:0]  read_index_i,
  output logic              op_valid_o,
  input  wire logic         op_ready_i,
  output op_e               op_kind_o,
  output logic              op_chan_o,
  output logic [AddrW-1:0]  op_addr_o,
  output logic              op_hit_o,
  output logic [7:0]        op_byte_o,
  output logic              op_key_o,
  output logic [31:0]       op_ts_o,
  output logic [31:0]       op_codec_o,
  output logic [31:0]       op_len_o,
  output logic              op_trunc_o
);

  logic [7:0]  hdr_q [HeaderBytes];
  logic [4:0]  pos_q;
  logic [7:0]  pch_q;
  logic [31:0] fill_q [2];
  logic [31:0] exp_size_q [2];
  logic [15:0] exp_frag_q [2];
  logic [31:0] ts_q [2];
  logic [31:0] codec_q [2];
  logic        key_q [2];
  logic [31:0] comp_q [2];

  logic        take, is_pkt, need_op;
  logic [7:0]  ch;
  logic        vld, c;
  logic [4:0]  pos_n;
  logic        hdr_done, store_ok, payload;
  logic [31:0] fill_n;
  logic [15:0] frag_num;
  logic        complete;
  logic        rc;
  logic        rhit;
  logic [31:0] cur_fill;
  logic [31:0] size_cur, ts_cur, codec_cur;
  logic [15:0] nfrag_cur;
  logic        key_set, key_cur;

  localparam logic [31:0] FB = 32'(FrameBytes);

  assign is_pkt = (req_type_i == REQ_PKT);
  assign ch     = (pos_q == 5'd0) ? channel_i : pch_q;
  assign vld    = (ch == 8'd1) || (ch == 8'd2);
  assign c      = vld && (ch == 8'd2);
  assign payload = is_pkt && (pos_q >= 5'(HeaderBytes)) && vld;
  assign frag_num = {hdr_q[1], hdr_q[0]};
  assign hdr_done = is_pkt && (pos_q == 5'(HeaderBytes - 1)) && vld
                    && (frag_num == 16'd0);

  // When fragment 0 finishes its header with this byte, the channel already
  // sees the fresh frame values.
  assign cur_fill  = hdr_done ? 32'd0 : fill_q[c];
  assign size_cur  = hdr_done ? {data_byte_i, hdr_q[14], hdr_q[13], hdr_q[12]}
                              : exp_size_q[c];
  assign nfrag_cur = hdr_done ? {hdr_q[3], hdr_q[2]} : exp_frag_q[c];
  assign ts_cur    = hdr_done ? {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]} : ts_q[c];
  assign codec_cur = hdr_done ? {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]} : codec_q[c];
  assign key_set   = payload && (frag_num == 16'd0) && !c
                     && (pos_q == 5'(HeaderBytes + 4));
  assign key_cur   = hdr_done ? 1'b0 : (key_set ? is_key_nal(data_byte_i) : key_q[c]);

  assign store_ok = payload && (cur_fill < FB);
  assign fill_n  = (payload && cur_fill != 32'hFFFF_FFFF) ? cur_fill + 32'd1 : cur_fill;
  assign pos_n   = (pos_q < PosMax) ? pos_q + 5'd1 : pos_q;
  // A packet that ends on its last header byte is already long enough to
  // complete a frame.
  assign complete = is_pkt && packet_last_i && vld && (pos_q >= 5'(HeaderBytes - 1))
                    && ((fill_n >= size_cur)
                        || ({16'd0, frag_num} + 32'd1 == {16'd0, nfrag_cur}));

  assign rc   = (channel_i == 8'd2);
  assign rhit = ((channel_i == 8'd1) || (channel_i == 8'd2))
                && ({16'd0, read_index_i} < comp_q[rc]) && ({16'd0, read_index_i} < FB);

  assign need_op = (req_type_i == REQ_READ) || store_ok || complete;
  assign ready_o = !need_op || op_ready_i;
  assign take    = valid_i && ready_o;

  // For descriptor ops the hit bit tells the back part to write the byte into
  // the store; payload ops are always written.
  always_comb begin
    op_valid_o = valid_i && need_op;
    op_kind_o  = OP_PAYLOAD;
    op_chan_o  = c;
    op_addr_o  = cur_fill[AddrW-1:0];
    op_hit_o   = store_ok;
    op_byte_o  = data_byte_i;
    op_key_o   = key_cur;
    op_ts_o    = ts_cur;
    op_codec_o = codec_cur;
    op_len_o   = fill_n;
    op_trunc_o = fill_n > FB;
    if (req_type_i == REQ_READ) begin
      op_kind_o = OP_READ;
      op_chan_o = rc;
      op_addr_o = AddrW'(read_index_i);
      op_hit_o  = rhit;
    end else if (complete) begin
      op_kind_o = OP_DESC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_pkt && pos_q < 5'(HeaderBytes)) begin
      hdr_q[pos_q[3:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      pch_q <= '0;
      for (int i = 0; i < 2; i++) begin
        fill_q[i] <= '0; exp_size_q[i] <= '0; exp_frag_q[i] <= '0;
        ts_q[i] <= '0; codec_q[i] <= '0; key_q[i] <= 1'b0; comp_q[i] <= '0;
      end
    end else if (take) begin
      if (req_type_i == REQ_FLUSH) begin
        fill_q[0] <= '0; fill_q[1] <= '0; comp_q[0] <= '0; comp_q[1] <= '0;
        pos_q <= '0;
      end else if (is_pkt) begin
        if (pos_q == 5'd0) pch_q <= channel_i;
        pos_q <= packet_last_i ? 5'd0 : pos_n;
        if (hdr_done) begin
          fill_q[c]     <= '0;
          exp_size_q[c] <= size_cur;
          exp_frag_q[c] <= nfrag_cur;
          ts_q[c]       <= ts_cur;
          codec_q[c]    <= codec_cur;
          key_q[c]      <= 1'b0;
        end
        if (payload) begin
          if (key_set) begin
            key_q[0] <= is_key_nal(data_byte_i);
          end
          if (store_ok) comp_q[c] <= '0;
          fill_q[c] <= fill_n;
        end
        if (complete) begin
          comp_q[c] <= (fill_n > FB) ? FB : fill_n;
          fill_q[c] <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/media_fragment_reassembler_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// media_fragment_reassembler_top
// Reassembles per-channel media frames from byte-wide packets.
// ---------------------------------------------------------------------------
// One request per cycle is taken. The front part parses headers and keeps the
// per-channel counters; a two-entry queue feeds the back part, which holds
// the frame store (two channels of FrameBytes each) behind one port, and a
// single output register. A packet's last byte that both stores payload and
// completes the frame travels as one descriptor operation that also carries
// its store write. Results are registered in the back part's output register
// after leaving the queue. The input stalls only while the queue is full,
// which happens when a result waits in the output register and further
// operations pile up behind it.
module media_fragment_reassembler_top import mfr_pkg::*; #(
  parameter int unsigned FrameBytes = FrameBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  channel_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_last_i,
  input  wire logic [15:0] read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic             is_video_o,
  output logic             is_keyframe_o,
  output logic [31:0]      timestamp_ms_o,
  output logic [31:0]      codec_fourcc_o,
  output logic [31:0]      frame_length_o,
  output logic             truncated_o,
  output logic [7:0]       read_byte_o,
  output logic             read_valid_o
);

  localparam int unsigned AddrW = $clog2(FrameBytes);
  localparam int unsigned OpW = 2 + 1 + AddrW + 1 + 8 + 1 + 32 + 32 + 32 + 1;

  logic             fv, fr;
  op_e              fk;
  logic             fc, fh, fkey, ftr;
  logic [AddrW-1:0] fa;
  logic [7:0]       fb;
  logic [31:0]      fts, fco, fl;

  logic           qv, qr;
  logic [OpW-1:0] qd;

  mfr_front #(.FrameBytes(FrameBytes)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .req_type_i, .channel_i, .data_byte_i, .packet_last_i, .read_index_i,
    .op_valid_o(fv), .op_ready_i(fr), .op_kind_o(fk), .op_chan_o(fc),
    .op_addr_o(fa), .op_hit_o(fh), .op_byte_o(fb), .op_key_o(fkey),
    .op_ts_o(fts), .op_codec_o(fco), .op_len_o(fl), .op_trunc_o(ftr)
  );

  mfr_queue #(.Width(OpW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fv), .in_ready_o(fr),
    .in_data_i({fk, fc, fa, fh, fb, fkey, fts, fco, fl, ftr}),
    .out_valid_o(qv), .out_ready_i(qr), .out_data_o(qd)
  );

  op_e              bk;
  logic             bc, bh, bkey, btr;
  logic [AddrW-1:0] ba;
  logic [7:0]       bb;
  logic [31:0]      bts, bco, bl;
  assign {bk, bc, ba, bh, bb, bkey, bts, bco, bl, btr} = qd;

  mfr_back #(.FrameBytes(FrameBytes)) u_back (
    .clk_i, .rst_ni,
    .op_valid_i(qv), .op_ready_o(qr), .op_kind_i(bk), .op_chan_i(bc),
    .op_addr_i(ba), .op_hit_i(bh), .op_byte_i(bb), .op_key_i(bkey),
    .op_ts_i(bts), .op_codec_i(bco), .op_len_i(bl), .op_trunc_i(btr),
    .out_valid_o, .out_ready_i, .result_kind_o, .is_video_o, .is_keyframe_o,
    .timestamp_ms_o, .codec_fourcc_o, .frame_length_o, .truncated_o,
    .read_byte_o, .read_valid_o
  );

endmodule
`default_nettype wire

@@ verif/mfr_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfr_checker
// Watches both channels of the reassembler, predicts its results and
// compares every result transfer field by field against the oldest one.
// ---------------------------------------------------------------------------
module mfr_checker import mfr_pkg::*; #(
  parameter int unsigned FrameBytes = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  channel_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_last_i,
  input  wire logic [15:0] read_index_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        result_kind_i,
  input  wire logic        is_video_i,
  input  wire logic        is_keyframe_i,
  input  wire logic [31:0] timestamp_ms_i,
  input  wire logic [31:0] codec_fourcc_i,
  input  wire logic [31:0] frame_length_i,
  input  wire logic        truncated_i,
  input  wire logic [7:0]  read_byte_i,
  input  wire logic        read_valid_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic        kind;
    logic        video;
    logic        key;
    logic [31:0] ts;
    logic [31:0] fourcc;
    logic [31:0] len;
    logic        trunc;
    logic [7:0]  rbyte;
    logic        rvalid;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [7:0]  hdr[16];
  logic [4:0]  pos_q;
  logic [7:0]  pkt_chan;
  logic [7:0]  store[2][int];
  logic [31:0] fill[2], exp_size[2], ts_q[2], cc_q[2], done_len[2];
  logic [15:0] exp_frags[2];
  logic        key_q[2];

  function automatic logic [15:0] h16(int at);
    return {hdr[at+1], hdr[at]};
  endfunction

  function automatic logic [31:0] h32(int at);
    return {h16(at + 2), h16(at)};
  endfunction

  function automatic logic key_nal(logic [7:0] b);
    return (b[6:1] == 6'd19) || (b[6:1] == 6'd20) || (b[6:1] == 6'd32)
        || (b[4:0] == 5'd5);
  endfunction

  task automatic track_request();
    frame_result_t r;
    logic        ok;
    int          c;
    logic [5:0]  p;
    r = '0;
    if (req_type_i == REQ_READ) begin
      r.kind = 1'b1;
      if (channel_i == 8'd1 || channel_i == 8'd2) begin
        c = channel_i - 1;
        if (read_index_i < done_len[c]) begin
          r.rbyte = store[c][read_index_i];
          r.rvalid = 1'b1;
        end
      end
      expected_results.push_back(r);
    end else if (req_type_i == REQ_FLUSH) begin
      fill = '{0, 0};
      done_len = '{0, 0};
      pos_q = '0;
    end else if (req_type_i == REQ_PKT) begin
      p = pos_q;
      if (p == 0) pkt_chan = channel_i;
      ok = (pkt_chan == 8'd1) || (pkt_chan == 8'd2);
      c = ok ? pkt_chan - 1 : 0;
      if (p < 16) begin
        hdr[p[3:0]] = data_byte_i;
        p++;
        if (p == 16 && ok && h16(0) == 0) begin
          fill[c] = 0;
          exp_size[c] = h32(12);
          exp_frags[c] = h16(2);
          ts_q[c] = h32(4);
          cc_q[c] = h32(8);
          key_q[c] = 1'b0;
        end
      end else begin
        if (ok) begin
          if (h16(0) == 0 && c == 0 && p == 20) key_q[c] = key_nal(data_byte_i);
          if (fill[c] < FrameBytes) begin
            store[c][fill[c]] = data_byte_i;
            done_len[c] = 0;
          end
          if (fill[c] != 32'hFFFF_FFFF) fill[c]++;
        end
        if (p < 31) p++;
      end
      pos_q = p[4:0];
      if (packet_last_i) begin
        pos_q = '0;
        if (p >= 16 && ok && (fill[c] >= exp_size[c] ||
            32'(h16(0)) + 1 == 32'(exp_frags[c]))) begin
          r.video = (c == 0);
          r.key = key_q[c];
          r.ts = ts_q[c];
          r.fourcc = cc_q[c];
          r.len = fill[c];
          r.trunc = fill[c] > FrameBytes;
          done_len[c] = (fill[c] > FrameBytes) ? FrameBytes : fill[c];
          fill[c] = 0;
          expected_results.push_back(r);
        end
      end
    end
  endtask

  task automatic compare_result();
    frame_result_t got, want;
    got = '{result_kind_i, is_video_i, is_keyframe_i, timestamp_ms_i, codec_fourcc_i,
            frame_length_i, truncated_i, read_byte_i, read_valid_i};
    if (expected_results.size() == 0) begin
      if (errors_o < 10) $display("ERROR: unexpected result %p", got);
      errors_o++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        if (errors_o < 10) $display("ERROR: expected %p, got %p", want, got);
        errors_o++;
      end
    end
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    pos_q = '0;
    pkt_chan = '0;
    foreach (hdr[i]) hdr[i] = '0;
    fill = '{0, 0};
    exp_size = '{0, 0};
    exp_frags = '{0, 0};
    ts_q = '{0, 0};
    cc_q = '{0, 0};
    key_q = '{0, 0};
    done_len = '{0, 0};
  end

  // Results are checked before the request of the same edge is tracked; a
  // result can never come from the request accepted at that same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i) track_request();
      pending_o = expected_results.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives packets, reads and flushes into the reassembler with random gaps
// and output stalls; the checker predicts and compares the results.
// ---------------------------------------------------------------------------
module tb;
  import mfr_pkg::*;

  localparam int unsigned FrameBytes = 1024;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = REQ_NONE;
  logic [7:0]  channel_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        packet_last_i = 1'b0;
  logic [15:0] read_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o, is_video_o, is_keyframe_o, truncated_o, read_valid_o;
  logic [31:0] timestamp_ms_o, codec_fourcc_o, frame_length_o;
  logic [7:0]  read_byte_o;
  int          errors, pending;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  bit          long_hold = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  media_fragment_reassembler_top #(.FrameBytes(FrameBytes)) dut (.*);

  mfr_checker #(.FrameBytes(FrameBytes)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .channel_i,
    .data_byte_i, .packet_last_i, .read_index_i, .out_valid_i(out_valid_o),
    .out_ready_i, .result_kind_i(result_kind_o), .is_video_i(is_video_o),
    .is_keyframe_i(is_keyframe_o), .timestamp_ms_i(timestamp_ms_o),
    .codec_fourcc_i(codec_fourcc_o), .frame_length_i(frame_length_o),
    .truncated_i(truncated_o), .read_byte_i(read_byte_o), .read_valid_i(read_valid_o),
    .errors_o(errors), .pending_o(pending)
  );

  // One transfer; the valid stays high if the next request follows at once.
  task automatic send_req(logic [1:0] rt, logic [7:0] ch, logic [7:0] db,
                          logic lst, logic [15:0] idx, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    channel_i <= ch;
    data_byte_i <= db;
    packet_last_i <= lst;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_packet(logic [7:0] ch, logic [15:0] frag, logic [15:0] nfrag,
                             logic [31:0] ts, logic [31:0] cc, logic [31:0] fsize,
                             int payload, logic [7:0] nal, bit gaps);
    logic [7:0] b[16];
    int total;
    b = '{frag[7:0], frag[15:8], nfrag[7:0], nfrag[15:8], ts[7:0], ts[15:8],
          ts[23:16], ts[31:24], cc[7:0], cc[15:8], cc[23:16], cc[31:24],
          fsize[7:0], fsize[15:8], fsize[23:16], fsize[31:24]};
    total = 16 + payload;
    for (int i = 0; i < total; i++) begin
      send_req(REQ_PKT, (i == 0) ? ch : 8'($urandom), (i < 16) ? b[i] :
               (i == 20 ? nal : 8'($urandom)), i == total - 1, '0, gaps);
    end
  endtask

  task automatic random_frame(bit gaps);
    logic [7:0] ch;
    int n, sz, pay;
    ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    n = $urandom_range(1, 3);
    sz = $urandom_range(0, 40);
    for (int f = 0; f < n; f++) begin
      pay = $urandom_range(0, 20);
      send_packet(ch, 16'(f), 16'(n), $urandom, $urandom, sz, pay,
                  8'($urandom), gaps);
    end
  endtask

  // Receiver: for every result it draws how many cycles it waits first.
  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      hold = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      while (long_hold) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Receiver holds off for a long stretch while the sender keeps going.
  initial begin
    wait (rst_ni);
    repeat (1500) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed part.
    send_req(REQ_READ, 8'd1, 8'h00, 1'b0, 16'hFFFF);
    send_packet(8'd1, 16'd0, 16'd1, 32'hFFFF_FFFF, 32'h3463_7668, 32'd6, 6,
                8'h26, 1'b1);
    send_req(REQ_READ, 8'd1, 8'hFF, 1'b1, 16'd5);
    send_req(REQ_READ, 8'd1, 8'h00, 1'b0, 16'd6);
    send_req(REQ_READ, 8'd2, 8'h00, 1'b0, 16'd0);
    send_packet(8'd1, 16'd0, 16'd2, 32'd0, 32'd0, 32'd2, 5, 8'h65, 1'b1);
    send_packet(8'd2, 16'd0, 16'd1, 32'h1234, 32'h6361_6161, 32'd0, 0, 8'h40, 1'b1);
    send_packet(8'd3, 16'd0, 16'd1, 32'd0, 32'd0, 32'd0, 4, 8'h0, 1'b1);
    send_req(REQ_PKT, 8'd1, 8'hFF, 1'b1, 16'd0);
    send_packet(8'd2, 16'd0, 16'd1, 32'd7, 32'd7, 32'hFFFF_FFFF, 40,
                8'h0, 1'b0);
    send_req(REQ_READ, 8'd2, 8'h00, 1'b0, 16'd39);
    send_req(REQ_READ, 8'd2, 8'h00, 1'b0, 16'd40);
    send_req(REQ_FLUSH, 8'd0, 8'h00, 1'b0, 16'd0);
    send_req(REQ_READ, 8'd2, 8'h00, 1'b0, 16'd0);
    send_req(REQ_NONE, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    // Random part: mostly well-formed frames, some noise and broken packets.
    for (int k = 0; k < 21; k++) begin
      case ($urandom_range(0, 9))
        0: send_req(REQ_READ, 8'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                    16'($urandom_range(0, 50)));
        1: send_req(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    16'($urandom));
        2: if ($urandom_range(0, 3) == 0) send_req(REQ_FLUSH, 8'($urandom), 8'd0, 1'b0,
                                                   16'd0);
        default: random_frame($urandom_range(0, 3) != 0);
      endcase
      send_req(REQ_READ, 8'($urandom_range(1, 2)), 8'd0, 1'b0,
               16'($urandom_range(0, 30)));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0 && idle_cycles < WatchdogLimit) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_back.sv
hw/rtl/mfr_queue.sv
hw/rtl/mfr_front.sv
hw/rtl/media_fragment_reassembler_top.sv
verif/mfr_checker.sv
verif/tb.sv
